// File: hdl/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// Shared types and constants of the radio channel scan tracker: command and
// class codes, packet type codes, table addressing and inter-module structs.
// ----------------------------------------------------------------------------
package rcst_pkg;

   localparam int NUM_CHANNELS_DEF = 33;
   localparam int CH_W             = 6;
   localparam int ID_W             = 24;
   localparam int CSR_IDX_W        = 2;
   localparam int NUM_CLASSES      = 3;
   localparam int ADDR_W           = 2 + CH_W;
   localparam int MEM_DEPTH        = NUM_CLASSES << CH_W;

   // commands
   localparam logic [1:0] CMD_PACKET  = 2'd0;
   localparam logic [1:0] CMD_HOP     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // device classes
   localparam logic [1:0] CLS_LINK  = 2'd0;
   localparam logic [1:0] CLS_PUMP  = 2'd1;
   localparam logic [1:0] CLS_METER = 2'd2;
   localparam logic [1:0] CLS_NONE  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINK_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PUMP_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_METER_ID = 2'd2;

   // packet type codes
   localparam logic [7:0] TYPE_LINK_A  = 8'hAA;
   localparam logic [7:0] TYPE_LINK_B  = 8'hAB;
   localparam logic [7:0] TYPE_PUMP_A  = 8'hA2;
   localparam logic [7:0] TYPE_PUMP_B  = 8'hA7;
   localparam logic [7:0] TYPE_METER   = 8'hA5;

   localparam logic [CH_W-1:0] GENERIC_CH     = 6'h20;
   localparam logic [7:0]      RESTART_VALUE  = 8'h01;
   localparam logic [7:0]      LINK_MIN_STR   = 8'd10;
   localparam logic [CH_W-1:0] LINK_NEAR_LIM  = 6'd30;
   localparam logic [CH_W-1:0] LINK_MAX_BEST  = 6'd32;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] device_class;
      logic [7:0] msg_type;
      logic [7:0] msg_byte1;
      logic [7:0] msg_byte2;
      logic [7:0] msg_byte3;
      logic [7:0] msg_byte4;
      logic       crc_error;
      logic [7:0] signal_strength;
      logic [7:0] radio_mode;
   } req_item_type;

   typedef struct packed {
      logic [7:0] best_mode;
      logic [7:0] best_strength;
      logic [7:0] try_mode;
      logic       found;
   } rsp_item_type;

   typedef struct packed {
      logic            rd_en;
      addr_type        rd_addr;
      logic            wr_en;
      addr_type        wr_addr;
      logic [7:0]      wr_data;
      logic            clr_pump;
   } mem_cmd_type;

   typedef struct packed {
      logic            hit;
      logic [1:0]      cls;
      logic [CH_W-1:0] ch;
      logic [7:0]      strength;
   } pkt_match_type;

   typedef struct packed {
      logic [CH_W-1:0] best_ch;
      logic [7:0]      best_str;
      logic            any_low;
      logic            has1;
      logic [CH_W-1:0] b1;
      logic            has2;
      logic [CH_W-1:0] b2;
   } scan_result_type;

endpackage

// File: hdl/rcst_req_if.sv
// ----------------------------------------------------------------------------
// rcst_req_if
// Request channel: one command word with its packet bytes and radio status.
// ----------------------------------------------------------------------------
interface rcst_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] device_class;
   logic [7:0] msg_type;
   logic [7:0] msg_byte1;
   logic [7:0] msg_byte2;
   logic [7:0] msg_byte3;
   logic [7:0] msg_byte4;
   logic       crc_error;
   logic [7:0] signal_strength;
   logic [7:0] radio_mode;

   modport source (
      output valid, cmd, device_class, msg_type, msg_byte1, msg_byte2, msg_byte3,
             msg_byte4, crc_error, signal_strength, radio_mode,
      input  ready
   );
   modport sink (
      input  valid, cmd, device_class, msg_type, msg_byte1, msg_byte2, msg_byte3,
             msg_byte4, crc_error, signal_strength, radio_mode,
      output ready
   );
endinterface

// File: hdl/rcst_rsp_if.sv
// ----------------------------------------------------------------------------
// rcst_rsp_if
// Response channel: best channel, its strength, scan channel and found flag.
// ----------------------------------------------------------------------------
interface rcst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] best_mode;
   logic [7:0] best_strength;
   logic [7:0] try_mode;
   logic       found;

   modport source (
      output valid, best_mode, best_strength, try_mode, found,
      input  ready
   );
   modport sink (
      input  valid, best_mode, best_strength, try_mode, found,
      output ready
   );
endinterface

// File: hdl/rcst_table_mem.sv
// ----------------------------------------------------------------------------
// rcst_table_mem
// Strength tables of all three classes in one synchronous memory, addressed
// by class and channel, with a per-entry valid bit so unwritten entries read
// as zero after reset and after a pump restart.
// ----------------------------------------------------------------------------
module rcst_table_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  rcst_pkg::mem_cmd_type mem_cmd,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [rcst_pkg::MEM_DEPTH];
   logic [rcst_pkg::MEM_DEPTH-1:0] valid_ff;
   logic [7:0] data_ff;
   logic       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         data_ff <= mem[mem_cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_cmd.clr_pump) begin
            for (int i = 0; i < (1 << rcst_pkg::CH_W); i++) begin
               valid_ff[{rcst_pkg::CLS_PUMP, rcst_pkg::CH_W'(i)}] <= 1'b0;
            end
         end
         if (mem_cmd.wr_en) begin
            valid_ff[mem_cmd.wr_addr] <= 1'b1;
         end
         if (mem_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[mem_cmd.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? data_ff : 8'd0;

endmodule

// File: hdl/rcst_pkt_match.sv
// ----------------------------------------------------------------------------
// rcst_pkt_match
// Packet decode: picks the class from type byte and device id, drops bad
// CRC and out-of-range channels, scales the generic channel strength.
// ----------------------------------------------------------------------------
module rcst_pkt_match #(
   parameter int NUM_CHANNELS = rcst_pkg::NUM_CHANNELS_DEF
) (
   input  rcst_pkg::req_item_type    item,
   input  logic [rcst_pkg::ID_W-1:0] link_id,
   input  logic [rcst_pkg::ID_W-1:0] pump_id,
   input  logic [rcst_pkg::ID_W-1:0] meter_id,
   input  logic [2:0]                found,
   output rcst_pkg::pkt_match_type   match
);

   logic [rcst_pkg::CH_W-1:0] ch;
   logic                      usable;
   logic                      link_hit;
   logic                      pump_hit;
   logic                      meter_hit;

   always_comb begin
      ch     = item.radio_mode[rcst_pkg::CH_W-1:0];
      usable = !item.crc_error && ({1'b0, ch} < (rcst_pkg::CH_W + 1)'(NUM_CHANNELS));

      link_hit  = (item.msg_type == rcst_pkg::TYPE_LINK_A
                   || item.msg_type == rcst_pkg::TYPE_LINK_B)
                  && {item.msg_byte2, item.msg_byte3, item.msg_byte4} == link_id
                  && !found[0];
      pump_hit  = (item.msg_type == rcst_pkg::TYPE_PUMP_A
                   || item.msg_type == rcst_pkg::TYPE_PUMP_B)
                  && {item.msg_byte1, item.msg_byte2, item.msg_byte3} == pump_id
                  && !found[1];
      meter_hit = item.msg_type == rcst_pkg::TYPE_METER
                  && {item.msg_byte1, item.msg_byte2, item.msg_byte3} == meter_id
                  && !found[2];

      match.hit      = usable && (link_hit || pump_hit || meter_hit);
      match.cls      = link_hit ? rcst_pkg::CLS_LINK
                     : pump_hit ? rcst_pkg::CLS_PUMP : rcst_pkg::CLS_METER;
      match.ch       = ch;
      // generic channel reads a quarter of the measured strength
      match.strength = (ch == rcst_pkg::GENERIC_CH) ? {2'b00, item.signal_strength[7:2]}
                                                   : item.signal_strength;
   end

endmodule

// File: hdl/rcst_scan_acc.sv
// ----------------------------------------------------------------------------
// rcst_scan_acc
// Accumulates one table sweep in channel order: strongest channel (ties to
// the higher one), any strength on the low channels, and the highest strong
// entry below each of the two possible next scan channels.
// ----------------------------------------------------------------------------
module rcst_scan_acc (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rcst_pkg::CH_W-1:0]   idx,
   input  logic [7:0]                  data,
   input  logic [rcst_pkg::CH_W-1:0]   c1,
   input  logic [rcst_pkg::CH_W-1:0]   c2,
   output rcst_pkg::scan_result_type   result
);

   rcst_pkg::scan_result_type acc_ff;
   rcst_pkg::scan_result_type acc_in;
   logic                      first;
   logic                      loud;

   always_comb begin
      acc_in = acc_ff;
      first  = (idx == '0);
      loud   = (data > rcst_pkg::LINK_MIN_STR);
      if (en) begin
         if (first || data >= acc_ff.best_str) begin
            acc_in.best_ch  = idx;
            acc_in.best_str = data;
         end
         acc_in.any_low = (first ? 1'b0 : acc_ff.any_low)
                          | (idx < rcst_pkg::GENERIC_CH && data != 8'd0);
         acc_in.has1 = first ? 1'b0 : acc_ff.has1;
         acc_in.has2 = first ? 1'b0 : acc_ff.has2;
         if (idx < c1 && loud) begin
            acc_in.has1 = 1'b1;
            acc_in.b1   = idx;
         end
         if (idx < c2 && loud) begin
            acc_in.has2 = 1'b1;
            acc_in.b2   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign result = acc_ff;

endmodule

// File: hdl/rf_channel_scan_tracker.sv
// ----------------------------------------------------------------------------
// rf_channel_scan_tracker
// Peak strength tracking and channel hopping for three radio device classes.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A matching packet reads its table entry
// and writes it when the new strength is higher, then every command for a
// used class sweeps that class's table through the single read port of the
// table memory, one channel a cycle; a word for the unused class skips the
// sweep. The result sits in an output register, so the next word is taken
// while it waits; the sweep stalls at its end until the previous result has
// gone. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rf_channel_scan_tracker #(
   parameter int NUM_CHANNELS = rcst_pkg::NUM_CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   rcst_req_if.sink                         req_chan,
   rcst_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [rcst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcst_pkg::ID_W-1:0]        csr_write_data
);

   localparam int CH_W = rcst_pkg::CH_W;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
   localparam logic [CH_W-1:0] NUM_CH  = CH_W'(NUM_CHANNELS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PKT_RD = 3'd1;
   localparam logic [2:0] ST_PKT_WR = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   logic [2:0]                  state_ff, state_in;
   rcst_pkg::req_item_type      item_ff, item_in;
   logic [CH_W-1:0]             cnt_ff, cnt_in;
   logic [CH_W-1:0]             sc_ff [rcst_pkg::NUM_CLASSES];
   logic [CH_W-1:0]             sc_in [rcst_pkg::NUM_CLASSES];
   logic [2:0]                  found_ff, found_in;
   logic [rcst_pkg::ID_W-1:0]   link_id_ff, link_id_in;
   logic [rcst_pkg::ID_W-1:0]   pump_id_ff, pump_id_in;
   logic [rcst_pkg::ID_W-1:0]   meter_id_ff, meter_id_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rcst_pkg::rsp_item_type      out_ff, out_in;
   logic                        acc_en_ff, acc_en_in;
   logic [CH_W-1:0]             acc_idx_ff, acc_idx_in;

   rcst_pkg::mem_cmd_type       mem_cmd;
   logic [7:0]                  rd_data;
   rcst_pkg::pkt_match_type     match;
   rcst_pkg::scan_result_type   acc;

   logic [1:0]                  cls;
   logic                        cls_ok;
   logic [1:0]                  cls_idx;
   logic [CH_W-1:0]             old_sc;
   logic [CH_W-1:0]             c1;
   logic [CH_W-1:0]             c2;
   logic [CH_W-1:0]             new_sc;
   logic [CH_W-1:0]             rep_sc;
   logic                        lk_has;
   logic [CH_W-1:0]             lk_b;
   logic                        lk_settle;
   logic [1:0]                  code;
   logic [2:0]                  after_pkt;

   rcst_table_mem u_table_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   rcst_pkt_match #(.NUM_CHANNELS(NUM_CHANNELS)) u_pkt_match (
      .item     (item_ff),
      .link_id  (link_id_ff),
      .pump_id  (pump_id_ff),
      .meter_id (meter_id_ff),
      .found    (found_ff),
      .match    (match)
   );

   rcst_scan_acc u_scan_acc (
      .clock  (clock),
      .en     (acc_en_ff),
      .idx    (acc_idx_ff),
      .data   (rd_data),
      .c1     (c1),
      .c2     (c2),
      .result (acc)
   );

   // class of the word in hand and the two candidate next scan channels
   always_comb begin
      cls     = item_ff.device_class;
      cls_ok  = (cls != rcst_pkg::CLS_NONE);
      cls_idx = cls_ok ? cls : rcst_pkg::CLS_LINK;
      old_sc  = sc_ff[cls_idx];
      c1      = (old_sc == LAST_CH) ? '0 : old_sc + 1'b1;
      c2      = (c1 == LAST_CH) ? '0 : c1 + 1'b1;
      new_sc  = (c1 == acc.best_ch) ? c2 : c1;
      lk_has  = (new_sc == c1) ? acc.has1 : acc.has2;
      lk_b    = (new_sc == c1) ? acc.b1 : acc.b2;
      lk_settle = lk_has && lk_b < rcst_pkg::LINK_MAX_BEST
                  && !(lk_b < rcst_pkg::LINK_NEAR_LIM
                       && {1'b0, new_sc} < ({1'b0, lk_b} + 7'd2));
      code      = cls + 2'd1;
      after_pkt = cls_ok ? ST_SCAN : ST_FIN;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      sc_in        = sc_ff;
      found_in     = found_ff;
      link_id_in   = link_id_ff;
      pump_id_in   = pump_id_ff;
      meter_id_in  = meter_id_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      acc_en_in    = (state_ff == ST_SCAN);
      acc_idx_in   = cnt_ff;
      mem_cmd      = '0;
      rep_sc       = old_sc;

      if (csr_write_en) begin
         case (csr_index)
            rcst_pkg::REG_LINK_ID:  link_id_in  = csr_write_data;
            rcst_pkg::REG_PUMP_ID:  pump_id_in  = csr_write_data;
            rcst_pkg::REG_METER_ID: meter_id_in = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               item_in.cmd             = req_chan.cmd;
               item_in.device_class    = req_chan.device_class;
               item_in.msg_type        = req_chan.msg_type;
               item_in.msg_byte1       = req_chan.msg_byte1;
               item_in.msg_byte2       = req_chan.msg_byte2;
               item_in.msg_byte3       = req_chan.msg_byte3;
               item_in.msg_byte4       = req_chan.msg_byte4;
               item_in.crc_error       = req_chan.crc_error;
               item_in.signal_strength = req_chan.signal_strength;
               item_in.radio_mode      = req_chan.radio_mode;
               cnt_in                  = '0;
               if (req_chan.cmd == rcst_pkg::CMD_RESTART) begin
                  // pump restart: drop the whole pump table, seed the generic channel if in range
                  mem_cmd.clr_pump = 1'b1;
                  if (NUM_CHANNELS > int'(rcst_pkg::GENERIC_CH)) begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = {rcst_pkg::CLS_PUMP, rcst_pkg::GENERIC_CH};
                     mem_cmd.wr_data = rcst_pkg::RESTART_VALUE;
                  end
                  sc_in[rcst_pkg::CLS_PUMP] = '0;
                  found_in[1]               = 1'b0;
               end
               if (req_chan.cmd == rcst_pkg::CMD_PACKET) begin
                  state_in = ST_PKT_RD;
               end else if (req_chan.device_class != rcst_pkg::CLS_NONE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_PKT_RD: begin
            if (match.hit) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = {match.cls, match.ch};
               state_in        = ST_PKT_WR;
            end else begin
               state_in = after_pkt;
            end
         end
         ST_PKT_WR: begin
            // sweep reads start only after this write lands, so no forwarding
            if (rd_data < match.strength) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = {match.cls, match.ch};
               mem_cmd.wr_data = match.strength;
            end
            state_in = after_pkt;
         end
         ST_SCAN: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = {cls, cnt_ff};
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CH) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (item_ff.cmd == rcst_pkg::CMD_HOP && cls_ok) begin
                  sc_in[cls_idx] = new_sc;
                  rep_sc         = new_sc;
                  if (cls == rcst_pkg::CLS_LINK) begin
                     if (!found_ff[0] && new_sc > 6'd1 && lk_settle) begin
                        found_in[0] = 1'b1;
                     end
                  end else if (new_sc < old_sc) begin
                     found_in[cls_idx] = acc.any_low;
                  end
               end
               if (cls_ok) begin
                  out_in.best_mode     = {code, acc.best_ch};
                  out_in.best_strength = acc.best_str;
                  out_in.try_mode      = (cls == rcst_pkg::CLS_PUMP) ? {2'b00, rep_sc}
                                                                     : {code, rep_sc};
                  out_in.found         = found_in[cls_idx];
               end else begin
                  out_in = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sc_ff        <= '{default: '0};
         found_ff     <= '0;
         link_id_ff   <= '0;
         pump_id_ff   <= '0;
         meter_id_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         acc_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sc_ff        <= sc_in;
         found_ff     <= found_in;
         link_id_ff   <= link_id_in;
         pump_id_ff   <= pump_id_in;
         meter_id_ff  <= meter_id_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_en_ff    <= acc_en_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      out_ff     <= out_in;
      acc_idx_ff <= acc_idx_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.best_mode     = out_ff.best_mode;
   assign rsp_chan.best_strength = out_ff.best_strength;
   assign rsp_chan.try_mode      = out_ff.try_mode;
   assign rsp_chan.found         = out_ff.found;

   // scan channels never leave the channel range
   a_sc_range: assert property (@(posedge clock) disable iff (reset)
      sc_ff[0] < NUM_CH && sc_ff[1] < NUM_CH && sc_ff[2] < NUM_CH)
      else $error("scan channel out of range");

   // table writes only for a packet update or a pump restart
   a_wr_phase: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> (state_ff == ST_PKT_WR || state_ff == ST_IDLE))
      else $error("table write outside update phase");

   // a new result is only loaded at the end of a word
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result loaded outside finish phase");

   // the pump settles only on a hop
   a_pump_found: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff[1]) |-> $past(state_ff == ST_FIN && item_ff.cmd == rcst_pkg::CMD_HOP))
      else $error("pump found flag set without a hop");

endmodule
